### design/assert_macros.svh
// assertion macros for the coupling-rate unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### design/kcr_pkg.sv
// shared types and constants for the coupling-rate unit
package kcr_pkg;

  localparam int MAX_OSC_DEF = 64;
  localparam int CNT_W = 7;
  localparam int SUM_W = 39;
  localparam int MAG_W = 38;
  localparam int PROD_W = 54;
  localparam int MUL_W = 17;

  localparam logic [MUL_W-1:0] SIN_C1 = 17'd102944;
  localparam logic [MUL_W-1:0] SIN_C3 = 17'd42334;
  localparam logic [MUL_W-1:0] SIN_C5 = 17'd5223;
  localparam logic [MUL_W-1:0] SIN_C7 = 17'd307;

  localparam logic [1:0] REQ_PHASE = 2'd0;
  localparam logic [1:0] REQ_LINK = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  localparam logic [1:0] CFG_OSC_COUNT = 2'd0;
  localparam logic [1:0] CFG_STRENGTH = 2'd1;
  localparam logic [1:0] CFG_WEIGHTED = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] osc_index;
    logic [5:0] peer_index;
    logic [15:0] phase_value;
    logic connected;
    logic [15:0] link_weight;
    logic [15:0] query_phase;
  } item_t;

  typedef struct packed {
    logic signed [24:0] rate;
    logic [6:0] neighbour_total;
  } result_t;

  typedef struct packed {
    logic start;
    logic [PROD_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage

### design/kuramoto_coupling_rate_unit.sv
// top level: phase and link stores, neighbour walk with shared multiplier
//
//  channel  | handshake             | word
//  ---------+-----------------------+-------------------------------
//  item in  | start, busy           | item (kcr_pkg::item_t)
//  result   | done strobe, 1 cycle  | result (kcr_pkg::result_t)
//  config   | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
// after reset, clearing all MAX_OSC*MAX_OSC link entries holds busy high
// loads are written straight from idle; a query reads and checks each peer,
// runs each connected peer through the sine steps (one shared 17x17 multiplier),
// then does a closing read, the gain multiply, the divider start, the serial
// division and the rounding
// the receiver cannot stall: done is high for exactly one cycle
module kuramoto_coupling_rate_unit #(
  parameter int MAX_OSC = kcr_pkg::MAX_OSC_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  kcr_pkg::item_t item,
  output logic done,
  output kcr_pkg::result_t result,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_OSC);
  localparam int K_W = $clog2(MAX_OSC + 1);
  localparam int DEPTH = MAX_OSC * MAX_OSC;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int MW = kcr_pkg::MUL_W;
  localparam int CW = kcr_pkg::CNT_W;
  localparam int PW = kcr_pkg::PROD_W;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD, S_CHK, S_UU, S_C7, S_T5, S_T3, S_T1, S_SIN, S_WT,
    S_P0, S_P1, S_P2, S_P3, S_DGO, S_DWAIT, S_RND
  } state_t;

  state_t state;

  logic [6:0] osc_count;
  logic [15:0] coupling_strength;
  logic weighted_mode;

  logic [15:0] phase_mem [MAX_OSC];
  logic [16:0] link_mem [DEPTH];
  logic [15:0] phase_q;
  logic [16:0] link_q;

  logic [ADDR_W-1:0] clr;
  logic [IDX_W-1:0] row;
  logic [15:0] trial;
  logic [K_W-1:0] k;
  logic [K_W-1:0] limit;
  logic [CW-1:0] count;
  logic signed [kcr_pkg::SUM_W-1:0] sum;
  logic [1:0] quad;
  logic [MW-1:0] u;
  logic [MW-1:0] u2;
  logic [15:0] weight;
  logic neg;
  logic [50:0] mag;
  logic [PW-1:0] acc;

  logic [MW-1:0] mul_a;
  logic [MW-1:0] mul_b;
  logic [2*MW-1:0] p;

  logic accept;
  logic row_ok;
  logic col_ok;
  logic ph_we;
  logic [IDX_W-1:0] ph_wa;
  logic [15:0] ph_wd;
  logic ln_we;
  logic [ADDR_W-1:0] ln_wa;
  logic [16:0] ln_wd;
  logic [ADDR_W-1:0] ln_ra;

  logic [15:0] d;
  logic [MW-1:0] u_q;
  logic [MW-1:0] p_hi;
  logic [18:0] s_inc;
  logic [14:0] s15;
  logic [30:0] term;
  logic [kcr_pkg::SUM_W-1:0] sum_abs;
  logic [PW:0] q_inc;
  logic [31:0] q_r;

  kcr_pkg::div_req_t div_req;
  kcr_pkg::div_rsp_t div_rsp;

  kcr_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;
  assign row_ok = (32'(item.osc_index) < MAX_OSC);
  assign col_ok = (32'(item.peer_index) < MAX_OSC);
  assign ln_ra = ADDR_W'(row) * ADDR_W'(MAX_OSC) + ADDR_W'(k);

  // memory write ports
  always_comb begin
    ph_we = 1'b0;
    ph_wa = IDX_W'(item.osc_index);
    ph_wd = item.phase_value;
    ln_we = 1'b0;
    ln_wa = ADDR_W'(item.osc_index) * ADDR_W'(MAX_OSC) + ADDR_W'(item.peer_index);
    ln_wd = {item.connected, item.link_weight};
    if (state == S_CLEAR) begin
      ln_we = 1'b1;
      ln_wa = clr;
      ln_wd = '0;
      ph_we = (32'(clr) < MAX_OSC);
      ph_wa = IDX_W'(clr);
      ph_wd = '0;
    end else if (accept) begin
      ph_we = (item.req_type == kcr_pkg::REQ_PHASE) && row_ok;
      ln_we = (item.req_type == kcr_pkg::REQ_LINK) && row_ok && col_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (ph_we) begin
      phase_mem[ph_wa] <= ph_wd;
    end
    phase_q <= phase_mem[IDX_W'(k)];
  end

  always_ff @(posedge clk) begin
    if (ln_we) begin
      link_mem[ln_wa] <= ln_wd;
    end
    link_q <= link_mem[ln_ra];
  end

  // sine and scaling helpers
  always_comb begin
    d = phase_q - trial;
    u_q = {1'b0, d[13:0], 2'b00};
    if (d[14]) begin
      u_q = 17'h10000 - u_q;
    end
    p_hi = p[32:16];
    s_inc = 19'(p[33:16]) + 19'd1;
    s15 = (s_inc[18:1] > 18'd32767) ? 15'h7fff : s_inc[15:1];
    term = weighted_mode ? p[30:0] : {s15, 16'h0000};
    sum_abs = sum[kcr_pkg::SUM_W-1] ? -sum : sum;
    q_inc = {1'b0, div_rsp.quotient} + (PW+1)'(1 << 22);
    q_r = q_inc[54:23];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_UU: begin
        mul_a = u;
        mul_b = u;
      end
      S_C7: begin
        mul_a = p_hi;
        mul_b = kcr_pkg::SIN_C7;
      end
      S_T5: begin
        mul_a = u2;
        mul_b = kcr_pkg::SIN_C5 - p_hi;
      end
      S_T3: begin
        mul_a = u2;
        mul_b = kcr_pkg::SIN_C3 - p_hi;
      end
      S_T1: begin
        mul_a = u;
        mul_b = kcr_pkg::SIN_C1 - p_hi;
      end
      S_SIN: begin
        mul_a = {2'b00, s15};
        mul_b = {1'b0, weight};
      end
      S_P0: begin
        mul_a = mag[16:0];
        mul_b = {1'b0, coupling_strength};
      end
      S_P1: begin
        mul_a = mag[33:17];
        mul_b = {1'b0, coupling_strength};
      end
      S_P2: begin
        mul_a = mag[50:34];
        mul_b = {1'b0, coupling_strength};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
  end

  always_comb begin
    div_req.start = (state == S_DGO);
    div_req.dividend = acc;
    div_req.divisor = (count == '0) ? CW'(1) : count;
  end

  always_ff @(posedge clk) begin
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kcr_pkg::CFG_OSC_COUNT: osc_count <= cfg_data[6:0];
        kcr_pkg::CFG_STRENGTH: coupling_strength <= cfg_data;
        kcr_pkg::CFG_WEIGHTED: weighted_mode <= cfg_data[0];
        default: ;
      endcase
    end
    if (rst) begin
      osc_count <= 7'd64;
      coupling_strength <= 16'd256;
      weighted_mode <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      done <= 1'b0;
      k <= '0;
      count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (32'(clr) == DEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && item.req_type == kcr_pkg::REQ_QUERY) begin
            row <= IDX_W'(item.osc_index);
            trial <= item.query_phase;
            k <= '0;
            count <= '0;
            sum <= '0;
            if (!row_ok) begin
              limit <= '0;
            end else if (32'(osc_count) > MAX_OSC) begin
              limit <= K_W'(MAX_OSC);
            end else begin
              limit <= K_W'(osc_count);
            end
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= (k == limit) ? S_P0 : S_CHK;
          neg <= sum[kcr_pkg::SUM_W-1];
          mag <= 51'(sum_abs);
        end
        S_CHK: begin
          if (link_q[16]) begin
            quad <= d[15:14];
            u <= u_q;
            weight <= link_q[15:0];
            state <= S_UU;
          end else begin
            k <= k + 1'b1;
            state <= S_RD;
          end
        end
        S_UU: state <= S_C7;
        S_C7: begin
          u2 <= p_hi;
          state <= S_T5;
        end
        S_T5: state <= S_T3;
        S_T3: state <= S_T1;
        S_T1: state <= S_SIN;
        S_SIN: begin
          if (weighted_mode) begin
            state <= S_WT;
          end else begin
            sum <= quad[1] ? sum - kcr_pkg::SUM_W'(term)
                           : sum + kcr_pkg::SUM_W'(term);
            count <= count + 1'b1;
            k <= k + 1'b1;
            state <= S_RD;
          end
        end
        S_WT: begin
          sum <= quad[1] ? sum - kcr_pkg::SUM_W'(term) : sum + kcr_pkg::SUM_W'(term);
          count <= count + 1'b1;
          k <= k + 1'b1;
          state <= S_RD;
        end
        S_P0: state <= S_P1;
        S_P1: begin
          acc <= PW'(p);
          state <= S_P2;
        end
        S_P2: begin
          acc <= acc + (PW'(p) << 17);
          state <= S_P3;
        end
        S_P3: begin
          acc <= acc + (PW'(p) << 34);
          state <= S_DGO;
        end
        S_DGO: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_rsp.done) begin
            state <= S_RND;
          end
        end
        S_RND: begin
          if (neg) begin
            result.rate <= (q_r > 32'd16777216) ? -25'sd16777216 : -$signed(q_r[24:0]);
          end else begin
            result.rate <= (q_r > 32'd16777215) ? 25'sd16777215 : $signed(q_r[24:0]);
          end
          result.neighbour_total <= count;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_NXT(a_done_single, clk, rst, done, !done)
  `ASSERT_NXT(a_query_busy, clk, rst, accept && item.req_type == kcr_pkg::REQ_QUERY, busy)
  `ASSERT_IMP(a_count_le_k, clk, rst, state != S_IDLE && state != S_CLEAR, 32'(count) <= 32'(k))
  `ASSERT_IMP(a_k_le_limit, clk, rst, state == S_CHK, k < limit)

endmodule

### design/kcr_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module kcr_div (
  input  logic clk,
  input  logic rst,
  input  kcr_pkg::div_req_t req,
  output kcr_pkg::div_rsp_t rsp
);

  localparam int PW = kcr_pkg::PROD_W;
  localparam int CW = kcr_pkg::CNT_W;
  localparam int IW = $clog2(PW);

  logic [PW-1:0] dvd;
  logic [CW-1:0] rem;
  logic [CW-1:0] dvs;
  logic [IW-1:0] cnt;
  logic run;
  logic done_q;
  logic [CW:0] rem_sh;
  logic [CW:0] rem_sub;

  assign rem_sh = {rem, dvd[PW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        dvd <= req.dividend;
        dvs <= req.divisor;
        rem <= '0;
        cnt <= IW'(PW - 1);
      end else if (run) begin
        if (rem_sh >= {1'b0, dvs}) begin
          rem <= rem_sub[CW-1:0];
          dvd <= {dvd[PW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[CW-1:0];
          dvd <= {dvd[PW-2:0], 1'b0};
        end
        if (cnt == '0) begin
          run <= 1'b0;
          done_q <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign rsp.done = done_q;
  assign rsp.quotient = dvd;

endmodule
